>>> sv/mst_pkg.sv
package mst_pkg;

   // sizes
   localparam int MAX_VERTICES = 32;
   localparam int WEIGHT_BITS  = 16;
   localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
   localparam int CNT_BITS     = VIDX_BITS + 1;
   localparam int ADDR_BITS    = 2 * VIDX_BITS;
   localparam int MEM_DEPTH    = 1 << ADDR_BITS;
   localparam int TOTAL_BITS   = 21;
   localparam int VCOUNT_BITS  = 6;

   localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = VCOUNT_BITS'(32);
   localparam logic [WEIGHT_BITS-1:0] NO_EDGE_RESET = WEIGHT_BITS'(65535);

   typedef logic [VIDX_BITS-1:0]   vidx_type;
   typedef logic [CNT_BITS-1:0]    cnt_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [WEIGHT_BITS-1:0] weight_type;
   typedef logic [TOTAL_BITS-1:0]  total_type;

   // operation codes of a request word
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // register indexes
   typedef enum logic {
      REG_VERTEX_COUNT = 1'b0,
      REG_NO_EDGE_KEY  = 1'b1
   } reg_type;

   // the matrix is symmetric, so only the upper triangle is addressed
   function automatic addr_type pair_addr(vidx_type x, vidx_type y);
      addr_type result;
      if (x < y) begin
         result = {x, y};
      end else begin
         result = {y, x};
      end
      return result;
   endfunction

   function automatic logic in_range(logic [4:0] v);
      return int'(v) < MAX_VERTICES;
   endfunction

   // zero counts as one, above the maximum saturates
   function automatic cnt_type clamp_count(logic [VCOUNT_BITS-1:0] v);
      cnt_type result;
      if (v == '0) begin
         result = cnt_type'(1);
      end else if (int'(v) > MAX_VERTICES) begin
         result = cnt_type'(MAX_VERTICES);
      end else begin
         result = cnt_type'(v);
      end
      return result;
   endfunction

endpackage

>>> sv/prim_min_spanning_tree_top.sv
// channel   direction  words                                  handshake
// req_      in         op, vertex_a, vertex_b, weight         req_valid / req_ready
// rsp_      out        is_summary, from/to_vertex, weights,   rsp_valid / rsp_ready
//                      edge_count, last
// csr       in/out     vertex_count (0x0), no_edge_key (0x4)  apb, pready tied high
//
// a load word is written to the matrix from idle; ready stays high in idle
// a run word grows the tree over n vertices, then the whole matrix is cleared;
// n is the clamped vertex count
// the matrix has a single read port and the scan looks at one vertex per cycle
// after reset the matrix is cleared before the first word is taken
// a stalled result holds the sequencer in its emit or summary state
module prim_min_spanning_tree_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [4:0]  req_vertex_a,
   input  logic [4:0]  req_vertex_b,
   input  logic [15:0] req_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_summary,
   output logic [4:0]  rsp_from_vertex,
   output logic [4:0]  rsp_to_vertex,
   output logic [15:0] rsp_edge_weight,
   output logic [20:0] rsp_total_weight,
   output logic [4:0]  rsp_edge_count,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mst_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,    // sweep zeros through the matrix
      ST_IDLE,     // take load and run words
      ST_INIT,     // reset keys and tree flags
      ST_SCAN,     // find the cheapest vertex outside the tree
      ST_ADD,      // put it in the tree, fetch its edge weight
      ST_EMIT,     // send the tree edge
      ST_RELAX,    // lower the keys of its neighbors
      ST_SUMMARY   // send total and count
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [VCOUNT_BITS-1:0] vcount_ff, vcount_in;
   weight_type             nokey_ff, nokey_in;

   // sequencer
   cnt_type    n_ff, n_in;
   cnt_type    idx_ff, idx_in;
   addr_type   clr_ff, clr_in;
   weight_type min_ff, min_in;
   vidx_type   pick_ff, pick_in;
   logic       found_ff, found_in;
   total_type  total_ff, total_in;
   vidx_type   edges_ff, edges_in;
   logic       rd_pend_ff, rd_pend_in;
   vidx_type   rd_vtx_ff, rd_vtx_in;

   // per-vertex tree state
   weight_type              key_ff [MAX_VERTICES];
   weight_type              key_in [MAX_VERTICES];
   vidx_type                attach_ff [MAX_VERTICES];
   vidx_type                attach_in [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] tree_ff, tree_in;
   logic [MAX_VERTICES-1:0] linked_ff, linked_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_summary_ff, rsp_summary_in;
   logic [4:0] rsp_from_ff, rsp_from_in;
   logic [4:0] rsp_to_ff, rsp_to_in;
   weight_type rsp_weight_ff, rsp_weight_in;
   total_type  rsp_total_ff, rsp_total_in;
   logic [4:0] rsp_count_ff, rsp_count_in;
   logic       rsp_last_ff, rsp_last_in;

   // adjacency matrix, upper triangle
   weight_type adj_mem [MEM_DEPTH];
   weight_type rd_data_ff;
   logic       mem_we;
   addr_type   mem_waddr;
   weight_type mem_wdata;
   logic       rd_en;
   addr_type   rd_addr;

   logic     out_free;
   logic     take;
   vidx_type cur;
   logic     csr_write;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign cur       = idx_ff[VIDX_BITS-1:0];
   assign take      = !tree_ff[cur] && (key_ff[cur] < min_ff);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   // register read
   always_comb begin
      unique case (reg_type'(paddr[2]))
         REG_VERTEX_COUNT: prdata = 32'(vcount_ff);
         REG_NO_EDGE_KEY:  prdata = 32'(nokey_ff);
      endcase
   end

   // register write; the user must write only while the block is idle, the block itself does not enforce it
   always_comb begin
      vcount_in = vcount_ff;
      nokey_in  = nokey_ff;
      if (csr_write) begin
         unique case (reg_type'(paddr[2]))
            REG_VERTEX_COUNT: vcount_in = pwdata[VCOUNT_BITS-1:0];
            REG_NO_EDGE_KEY:  nokey_in  = pwdata[WEIGHT_BITS-1:0];
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      idx_in     = idx_ff;
      clr_in     = clr_ff;
      min_in     = min_ff;
      pick_in    = pick_ff;
      found_in   = found_ff;
      total_in   = total_ff;
      edges_in   = edges_ff;
      rd_pend_in = 1'b0;
      rd_vtx_in  = rd_vtx_ff;
      key_in     = key_ff;
      attach_in  = attach_ff;
      tree_in    = tree_ff;
      linked_in  = linked_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_summary_in = rsp_summary_ff;
      rsp_from_in    = rsp_from_ff;
      rsp_to_in      = rsp_to_ff;
      rsp_weight_in  = rsp_weight_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  if (in_range(req_vertex_a) && in_range(req_vertex_b)) begin
                     mem_we    = 1'b1;
                     mem_waddr = pair_addr(vidx_type'(req_vertex_a), vidx_type'(req_vertex_b));
                     mem_wdata = weight_type'(req_weight);
                  end
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            n_in = clamp_count(vcount_ff);
            for (int i = 0; i < MAX_VERTICES; i++) begin
               key_in[i] = nokey_ff;
            end
            key_in[0] = '0;     // root
            tree_in   = '0;
            linked_in = '0;
            total_in  = '0;
            edges_in  = '0;
            idx_in    = '0;
            min_in    = nokey_ff;
            found_in  = 1'b0;
            pick_in   = '0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (take) begin
               min_in   = key_ff[cur];
               pick_in  = cur;
               found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == n_ff - 1'b1) begin
               if (found_ff || take) begin
                  state_in = ST_ADD;
               end else begin
                  state_in = ST_SUMMARY;
               end
            end
         end
         ST_ADD: begin
            tree_in[pick_ff] = 1'b1;
            idx_in           = '0;
            if (linked_ff[pick_ff]) begin
               rd_en    = 1'b1;
               rd_addr  = pair_addr(pick_ff, attach_ff[pick_ff]);
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RELAX;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_summary_in = 1'b0;
               rsp_from_in    = 5'(attach_ff[pick_ff]);
               rsp_to_in      = 5'(pick_ff);
               rsp_weight_in  = rd_data_ff;
               rsp_total_in   = '0;
               rsp_count_in   = '0;
               rsp_last_in    = 1'b0;
               total_in       = total_ff + TOTAL_BITS'(rd_data_ff);
               edges_in       = edges_ff + 1'b1;
               state_in       = ST_RELAX;
            end
         end
         ST_RELAX: begin
            // issue one row read per cycle, update the key in the cycle after its read
            if (idx_ff < n_ff) begin
               rd_en      = 1'b1;
               rd_addr    = pair_addr(pick_ff, cur);
               rd_vtx_in  = cur;
               idx_in     = idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && rd_data_ff != '0 && !tree_ff[rd_vtx_ff] &&
                rd_data_ff < key_ff[rd_vtx_ff]) begin
               key_in[rd_vtx_ff]    = rd_data_ff;
               attach_in[rd_vtx_ff] = pick_ff;
               linked_in[rd_vtx_ff] = 1'b1;
            end
            if (idx_ff == n_ff && !rd_pend_ff) begin
               idx_in   = '0;
               min_in   = nokey_ff;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_summary_in = 1'b1;
               rsp_from_in    = '0;
               rsp_to_in      = '0;
               rsp_weight_in  = '0;
               rsp_total_in   = total_ff;
               rsp_count_in   = 5'(edges_ff);
               rsp_last_in    = 1'b1;
               clr_in         = '0;
               state_in       = ST_CLEAR;
            end
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vcount_ff    <= VCOUNT_RESET;
         nokey_ff     <= NO_EDGE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         vcount_ff    <= vcount_in;
         nokey_ff     <= nokey_in;
      end
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      min_ff         <= min_in;
      pick_ff        <= pick_in;
      found_ff       <= found_in;
      total_ff       <= total_in;
      edges_ff       <= edges_in;
      rd_vtx_ff      <= rd_vtx_in;
      key_ff         <= key_in;
      attach_ff      <= attach_in;
      tree_ff        <= tree_in;
      linked_ff      <= linked_in;
      rsp_summary_ff <= rsp_summary_in;
      rsp_from_ff    <= rsp_from_in;
      rsp_to_ff      <= rsp_to_in;
      rsp_weight_ff  <= rsp_weight_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // matrix: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         adj_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= adj_mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_summary   = rsp_summary_ff;
   assign rsp_from_vertex  = rsp_from_ff;
   assign rsp_to_vertex    = rsp_to_ff;
   assign rsp_edge_weight  = 16'(rsp_weight_ff);
   assign rsp_total_weight = rsp_total_ff;
   assign rsp_edge_count   = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> tb/tb_prim_min_spanning_tree_top.sv
module tb_prim_min_spanning_tree_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mst_pkg::*;

   // cycles with no handshake at all before the run is declared hung
   localparam int WATCHDOG_LIMIT = 20000;
   // matrix clear after a run or after reset, plus margin
   localparam int SETTLE_CYCLES  = 1100;
   // receiver hold-off that lets the block back up into its input
   localparam int LONG_HOLD      = 400;

   // one result word as the block presents it
   typedef struct packed {
      logic       summary;
      vidx_type   from_v;
      vidx_type   to_v;
      weight_type edge_w;
      total_type  total_w;
      logic [4:0] edges;
      logic       last;
   } tree_word_type;

   // block ports; the inputs are all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_LOAD;
   logic [4:0]  req_vertex_a = '0;
   logic [4:0]  req_vertex_b = '0;
   logic [15:0] req_weight = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_is_summary;
   logic [4:0]  rsp_from_vertex;
   logic [4:0]  rsp_to_vertex;
   logic [15:0] rsp_edge_weight;
   logic [20:0] rsp_total_weight;
   logic [4:0]  rsp_edge_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // mirror of the block: edge weights and the two registers
   weight_type  adjacency [MAX_VERTICES][MAX_VERTICES];
   logic [5:0]  vertex_count_reg;
   weight_type  no_edge_reg;

   // tree edges and summaries still to come out, oldest first
   tree_word_type  tree_words_due [$];
   tree_word_type  seen_word;
   tree_word_type  due_word;

   int          fail_count = 0;
   int          words_sent = 0;
   int          idle_cycles = 0;
   // receiver hold-off request, consumed by the receiver process
   int          hold_cycles = 0;
   // no idling on either side once set
   bit          calm = 1'b0;

   prim_min_spanning_tree_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .req_weight      (req_weight),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_is_summary  (rsp_is_summary),
      .rsp_from_vertex (rsp_from_vertex),
      .rsp_to_vertex   (rsp_to_vertex),
      .rsp_edge_weight (rsp_edge_weight),
      .rsp_total_weight(rsp_total_weight),
      .rsp_edge_count  (rsp_edge_count),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   function automatic void clear_matrix();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         for (int j = 0; j < MAX_VERTICES; j++) begin
            adjacency[i][j] = '0;
         end
      end
   endfunction

   // vertices taking part in a run: zero means one, above the max saturates
   function automatic int span_size();
      int n;
      n = int'(vertex_count_reg);
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_VERTICES) begin
         n = MAX_VERTICES;
      end
      return n;
   endfunction

   // grow the tree from vertex 0, queue each joining edge, then the summary
   function automatic void predict_tree();
      int            n;
      int            pick;
      bit            found;
      weight_type    min_key;
      weight_type    w;
      weight_type    key_of [MAX_VERTICES];
      bit            placed [MAX_VERTICES];
      bit            linked [MAX_VERTICES];
      int            parent_of [MAX_VERTICES];
      total_type     total;
      int            edge_total;
      tree_word_type word;
      n = span_size();
      for (int i = 0; i < n; i++) begin
         key_of[i] = no_edge_reg;
         placed[i] = 1'b0;
         linked[i] = 1'b0;
         parent_of[i] = 0;
      end
      key_of[0] = '0;
      total = '0;
      edge_total = 0;
      found = 1'b1;
      while (found) begin
         found = 1'b0;
         min_key = no_edge_reg;
         pick = 0;
         // strict compare keeps the lowest-numbered vertex on a tie
         for (int i = 0; i < n; i++) begin
            if (!placed[i] && key_of[i] < min_key) begin
               min_key = key_of[i];
               pick = i;
               found = 1'b1;
            end
         end
         if (found) begin
            placed[pick] = 1'b1;
            if (linked[pick]) begin
               w = adjacency[pick][parent_of[pick]];
               total = total + total_type'(w);
               edge_total++;
               word = '{summary: 1'b0, from_v: vidx_type'(parent_of[pick]),
                        to_v: vidx_type'(pick), edge_w: w, total_w: '0,
                        edges: '0, last: 1'b0};
               tree_words_due.push_back(word);
            end
            // relax neighbors; zero weight means no edge, self loops never win
            for (int v = 0; v < n; v++) begin
               w = adjacency[pick][v];
               if (w != '0 && !placed[v] && w < key_of[v]) begin
                  key_of[v] = w;
                  parent_of[v] = pick;
                  linked[v] = 1'b1;
               end
            end
         end
      end
      word = '{summary: 1'b1, from_v: '0, to_v: '0, edge_w: '0, total_w: total,
               edges: 5'(edge_total), last: 1'b1};
      tree_words_due.push_back(word);
      clear_matrix();
   endfunction

   function automatic string word_text(tree_word_type t);
      return $sformatf("summary=%0d from=%0d to=%0d weight=%0d total=%0d edges=%0d last=%0d",
                       t.summary, t.from_v, t.to_v, t.edge_w, t.total_w, t.edges, t.last);
   endfunction

   // ---------------------------------------------------------------
   // result checking, sampled at the rising edge
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         seen_word = '{rsp_is_summary, rsp_from_vertex, rsp_to_vertex, rsp_edge_weight,
                       rsp_total_weight, rsp_edge_count, rsp_last};
         if (tree_words_due.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected result word: %s", word_text(seen_word));
            end
            fail_count++;
         end else begin
            due_word = tree_words_due.pop_front();
            if (seen_word !== due_word) begin
               if (fail_count < 10) begin
                  $display("result mismatch\n  expected %s\n  actual   %s",
                           word_text(due_word), word_text(seen_word));
               end
               fail_count++;
            end
         end
      end
   end

   // watchdog: any accepted word on any port counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver pacing: random stall bursts, or one long hold on request
   // ---------------------------------------------------------------

   initial begin : rsp_pacing
      int stall;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            // long hold-off counted here, sender keeps offering words
            rsp_ready = 1'b0;
            stall = hold_cycles;
            hold_cycles = 0;
            repeat (stall - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 4) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   // offer one word, hold it until taken, then update the mirror
   task automatic send_word(logic op, vidx_type a, vidx_type b, weight_type w);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_vertex_a = a;
      req_vertex_b = b;
      req_weight = w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (op == OP_LOAD) begin
         adjacency[a][b] = w;
         adjacency[b][a] = w;
      end else begin
         predict_tree();
      end
   endtask

   // run word: its endpoint and weight fields are don't-care
   task automatic send_run();
      send_word(OP_RUN, vidx_type'($urandom_range(0, 31)), vidx_type'($urandom_range(0, 31)),
                weight_type'($urandom_range(0, 65535)));
   endtask

   // sender pauses until every queued result has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (tree_words_due.size() != 0) @(posedge clock);
   endtask

   // drained and past the matrix clear, safe for register writes
   task automatic settle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the write lands when pready is seen
   task automatic csr_write(reg_type sel, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {sel, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (sel == REG_VERTEX_COUNT) begin
         vertex_count_reg = value[5:0];
      end else begin
         no_edge_reg = value[15:0];
      end
   endtask

   // weight styles: tiny (lots of ties), full range, or hugging the no-edge key
   function automatic weight_type pick_weight(int style, weight_type key);
      int lo;
      int hi;
      lo = (int'(key) > 8) ? int'(key) - 8 : 1;
      hi = (int'(key) < 65527) ? int'(key) + 8 : 65535;
      unique case (style)
         0: begin
            return weight_type'($urandom_range(1, 4));
         end
         1: begin
            return weight_type'($urandom_range(1, 65535));
         end
         default: begin
            return weight_type'($urandom_range(lo, hi));
         end
      endcase
   endfunction

   // random spanning tree over n vertices, extra edges and noise, then a run
   task automatic send_graph(int n, weight_type key);
      int order [MAX_VERTICES];
      int style;
      int skip;
      int j;
      int t;
      int extra;
      style = (key < 256) ? (($urandom_range(0, 1) == 0) ? 0 : 2) : $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
         order[i] = i;
      end
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      // now and then drop one tree edge so the graph falls apart
      skip = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
      for (int i = 1; i < n; i++) begin
         if (i != skip) begin
            send_word(OP_LOAD, vidx_type'(order[i]), vidx_type'(order[$urandom_range(0, i - 1)]),
                      pick_weight(style, key));
         end
      end
      extra = $urandom_range(0, n / 2 + 1);
      repeat (extra) begin
         if ($urandom_range(0, 4) == 0) begin
            // noise: any endpoints, any weight, possibly outside the span
            send_word(OP_LOAD, vidx_type'($urandom_range(0, 31)),
                      vidx_type'($urandom_range(0, 31)), weight_type'($urandom_range(0, 65535)));
         end else begin
            // overwrite, removal or parallel path inside the span
            send_word(OP_LOAD, vidx_type'($urandom_range(0, n - 1)),
                      vidx_type'($urandom_range(0, n - 1)),
                      ($urandom_range(0, 5) == 0) ? weight_type'(0) : pick_weight(style, key));
         end
      end
      send_run();
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // reset settings: overwrite, removal, self loop, extreme vertices and
   // weights, an unreachable vertex, a run, then a second run on the cleared matrix
   task automatic test_basic_tree();
      send_word(OP_LOAD, 5'd0, 5'd1, 16'hFFFF);
      send_word(OP_LOAD, 5'd1, 5'd0, 16'd3);
      send_word(OP_LOAD, 5'd1, 5'd2, 16'hFFFE);
      send_word(OP_LOAD, 5'd2, 5'd2, 16'd7);
      send_word(OP_LOAD, 5'd31, 5'd0, 16'h8000);
      send_word(OP_LOAD, 5'd3, 5'd31, 16'd5);
      send_word(OP_LOAD, 5'd3, 5'd4, 16'd9);
      send_word(OP_LOAD, 5'd4, 5'd3, 16'd0);
      send_word(OP_RUN, 5'd31, 5'd31, 16'hFFFF);
      send_run();
   endtask

   // vertex count zero and saturated, no-edge key at zero and just above weights
   task automatic test_count_extremes();
      settle();
      csr_write(REG_VERTEX_COUNT, 32'd0);
      send_word(OP_LOAD, 5'd0, 5'd1, 16'd4);
      send_run();
      settle();
      csr_write(REG_VERTEX_COUNT, 32'd63);
      send_word(OP_LOAD, 5'd0, 5'd31, 16'd1);
      send_run();
      settle();
      csr_write(REG_VERTEX_COUNT, 32'd2);
      csr_write(REG_NO_EDGE_KEY, 32'd0);
      send_word(OP_LOAD, 5'd0, 5'd1, 16'd1);
      send_run();
      settle();
      csr_write(REG_NO_EDGE_KEY, 32'd1);
      send_word(OP_LOAD, 5'd0, 5'd1, 16'd1);
      send_run();
      settle();
      csr_write(REG_NO_EDGE_KEY, 32'd2);
      send_word(OP_LOAD, 5'd0, 5'd1, 16'd1);
      send_run();
   endtask

   // phases of random graphs, each under its own register settings
   task automatic test_random_graphs(int word_budget);
      int         sizes [8] = '{3, 8, 1, 32, 5, 63, 12, 2};
      int         phase;
      weight_type key;
      phase = 0;
      while (words_sent < word_budget) begin
         settle();
         unique case (phase % 4)
            0: key = 16'hFFFF;
            1: key = weight_type'($urandom_range(2, 65534));
            2: key = weight_type'($urandom_range(2, 60));
            default: key = 16'hFFFF;
         endcase
         csr_write(REG_VERTEX_COUNT, 32'(sizes[phase % 8]));
         csr_write(REG_NO_EDGE_KEY, 32'(key));
         repeat (2) send_graph(span_size(), key);
         phase++;
      end
   endtask

   // receiver holds off long while graphs keep coming, input must back up
   task automatic test_stalled_receiver();
      settle();
      csr_write(REG_VERTEX_COUNT, 32'd10);
      csr_write(REG_NO_EDGE_KEY, 32'hFFFF);
      hold_cycles = LONG_HOLD;
      repeat (3) send_graph(span_size(), no_edge_reg);
   endtask

   // sender goes quiet until every result is back, between graphs
   task automatic test_drained_pause();
      send_graph(span_size(), no_edge_reg);
      wait_drained();
      send_graph(span_size(), no_edge_reg);
      wait_drained();
      send_graph(span_size(), no_edge_reg);
   endtask

   // last part with no idling: a full-size graph and a small one
   task automatic test_calm_tail();
      settle();
      calm = 1'b1;
      csr_write(REG_VERTEX_COUNT, 32'd32);
      csr_write(REG_NO_EDGE_KEY, 32'hFFFF);
      send_graph(span_size(), no_edge_reg);
      settle();
      csr_write(REG_VERTEX_COUNT, 32'd6);
      csr_write(REG_NO_EDGE_KEY, 32'd500);
      send_graph(span_size(), no_edge_reg);
   endtask

   initial begin
      clear_matrix();
      vertex_count_reg = VCOUNT_RESET;
      no_edge_reg = NO_EDGE_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_tree();
      test_count_extremes();
      test_random_graphs(240);
      test_stalled_receiver();
      test_drained_pause();
      test_calm_tail();

      // everything back, then let the final clear run out
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && tree_words_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
